>>> rtl/puct_pkg.sv
// Shared types and constants for the PUCT action selector.
`default_nettype none
package puct_pkg;

   localparam int unsigned IndexWidth = 6;
   localparam int unsigned ScoreWidth = 48;
   localparam logic [15:0] ExploreReset = 16'd256;
   localparam int unsigned SqrtSteps = 24;
   localparam int unsigned DivSteps = 32;

   // One action as it travels from the front to the back.
   typedef struct packed {
      logic [15:0] prior_prob;
      logic [15:0] child_visits;
      logic signed [31:0] value_sum;
      logic [15:0] parent_visits;
      logic final_item;
      logic [IndexWidth-1:0] index;
      logic first;
   } item_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_MUL,
      ST_DIV_SETUP,
      ST_DIV,
      ST_UPDATE
   } state_type;

endpackage
`default_nettype wire

>>> rtl/puct_action_select.sv
// Top level of the PUCT action selector: front queue plus scoring back end.
// The back end dequeues each action, multiplies, runs two 32-step dividers and updates the leader; the first
// action of a set also takes a square root of the parent count before the multiply.
// A result appears in the cycle after the final action's update and holds while stalled.
// The two-entry front queue accepts up to two actions ahead of the back end.
// Synchronous active-high reset clears the queue, set position, leader and output.
`default_nettype none
module puct_action_select #(
   parameter int unsigned MAX_ACTIONS = 64
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [15:0] csr_explore_weight,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [15:0] req_prior_prob,
   input wire logic [15:0] req_child_visits,
   input wire logic signed [31:0] req_value_sum,
   input wire logic [15:0] req_parent_visits,
   input wire logic req_final_item,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [5:0] rsp_best_index,
   output logic signed [47:0] rsp_best_score
);

   logic head_valid;
   logic head_pop;
   puct_pkg::item_type head_item;

   puct_front #(.MAX_ACTIONS(MAX_ACTIONS)) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_prior_prob(req_prior_prob),
      .req_child_visits(req_child_visits),
      .req_value_sum(req_value_sum),
      .req_parent_visits(req_parent_visits),
      .req_final_item(req_final_item),
      .head_valid(head_valid),
      .head_item(head_item),
      .head_pop(head_pop)
   );

   puct_back u_back (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_explore_weight(csr_explore_weight),
      .head_valid(head_valid),
      .head_item(head_item),
      .head_pop(head_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_best_index(rsp_best_index),
      .rsp_best_score(rsp_best_score)
   );

endmodule
`default_nettype wire

>>> rtl/puct_front.sv
// Front end: accepts action beats, numbers them within a set and queues them.
`default_nettype none
module puct_front #(
   parameter int unsigned MAX_ACTIONS = 64
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [15:0] req_prior_prob,
   input wire logic [15:0] req_child_visits,
   input wire logic signed [31:0] req_value_sum,
   input wire logic [15:0] req_parent_visits,
   input wire logic req_final_item,
   output logic head_valid,
   output puct_pkg::item_type head_item,
   input wire logic head_pop
);

   localparam int unsigned CountWidth = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;

   logic [CountWidth-1:0] count_ff, count_in;
   puct_pkg::item_type queue_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic accept;
   puct_pkg::item_type new_item;

   assign req_stall = (fill_ff == 2'd2);
   assign accept = req_valid && !req_stall;
   assign head_valid = (fill_ff != 2'd0);
   assign head_item = queue_ff[rd_ptr_ff];

   // Classify the incoming beat: its position in the set and whether it opens one.
   always_comb begin
      new_item.prior_prob = req_prior_prob;
      new_item.child_visits = req_child_visits;
      new_item.value_sum = req_value_sum;
      new_item.parent_visits = req_parent_visits;
      new_item.final_item = req_final_item;
      new_item.index = puct_pkg::IndexWidth'(count_ff);
      new_item.first = (count_ff == '0);
   end

   // Position counter saturates at the last slot and restarts after a final beat.
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_final_item) begin
            count_in = '0;
         end else if (count_ff < CountWidth'(MAX_ACTIONS - 1)) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // Two-entry queue pointers and fill level.
   always_comb begin
      wr_ptr_in = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in = fill_ff + {1'b0, accept} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   // The queue never overflows, is never popped empty, and fills by one on an accept without a pop.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'd2) else $error("queue fill out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid) else $error("pop from empty queue");
   a_fill_tracks: assert property (@(posedge clock) disable iff (reset)
      (accept && !head_pop) |=> fill_ff == $past(fill_ff) + 2'd1)
      else $error("queue fill did not advance");

endmodule
`default_nettype wire

>>> rtl/puct_back.sv
// Back end: scores one queued action at a time and keeps the running best.
`default_nettype none
module puct_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [15:0] csr_explore_weight,
   input wire logic head_valid,
   input wire puct_pkg::item_type head_item,
   output logic head_pop,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [5:0] rsp_best_index,
   output logic signed [47:0] rsp_best_score
);

   puct_pkg::state_type state_ff, state_in;
   puct_pkg::item_type cur_ff, cur_in;
   logic [15:0] explore_ff, explore_in;
   // Square root unit.
   logic [47:0] rad_ff, rad_in;
   logic [25:0] srem_ff, srem_in;
   logic [23:0] root_ff, root_in;
   // Product c * P * sqrt(N).
   logic [31:0] cp_ff, cp_in;
   logic [55:0] num;
   // Two restoring dividers sharing one step counter.
   logic [31:0] qa_ff, qa_in;
   logic [16:0] ra_ff, ra_in;
   logic [31:0] qb_ff, qb_in;
   logic [16:0] rb_ff, rb_in;
   logic [4:0] step_ff, step_in;
   // Running best and output register.
   logic [5:0] lead_idx_ff, lead_idx_in;
   logic signed [47:0] lead_score_ff, lead_score_in;
   logic out_valid_ff, out_valid_in;
   logic [5:0] out_idx_ff, out_idx_in;
   logic signed [47:0] out_score_ff, out_score_in;

   logic [26:0] srem_t, strial;
   logic sge;
   logic [17:0] ra_t, rb_t, div_a, div_b;
   logic age, bge;
   logic [16:0] n_plus;
   logic [32:0] q_val;
   logic signed [47:0] score;
   logic take_lead;
   logic out_free;
   logic update_go;
   logic [31:0] vmag;

   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_best_index = out_idx_ff;
   assign rsp_best_score = out_score_ff;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign update_go = (state_ff == puct_pkg::ST_UPDATE) && (!cur_ff.final_item || out_free);
   assign head_pop = (state_ff == puct_pkg::ST_IDLE) && head_valid;

   // One square root step: two radicand bits in, one root bit out.
   always_comb begin
      srem_t = {srem_ff[24:0], rad_ff[47:46]};
      strial = {1'b0, root_ff, 2'b01};
      sge = (srem_t >= strial);
   end

   // Full product c * P * sqrt(N), formed once per action.
   always_comb begin
      num = {24'd0, cp_ff} * {32'd0, root_ff};
   end

   // One step of each divider.
   always_comb begin
      n_plus = {1'b0, cur_ff.child_visits} + 17'd1;
      div_a = {2'b00, cur_ff.child_visits};
      div_b = {1'b0, n_plus};
      ra_t = {ra_ff, qa_ff[31]};
      rb_t = {rb_ff, qb_ff[31]};
      age = (ra_t >= div_a);
      bge = (rb_t >= div_b);
   end

   // Score from the quotients and the new leader.
   always_comb begin
      if (cur_ff.child_visits == 16'd0) begin
         q_val = 33'd0;
      end else if (cur_ff.value_sum[31]) begin
         q_val = 33'd0 - {1'b0, qa_ff};
      end else begin
         q_val = {1'b0, qa_ff};
      end
      score = {{15{q_val[32]}}, q_val} + {16'd0, qb_ff};
      take_lead = cur_ff.first || (score > lead_score_ff);
      vmag = cur_ff.value_sum[31] ? (32'd0 - cur_ff.value_sum) : cur_ff.value_sum;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         puct_pkg::ST_IDLE: begin
            if (head_valid) begin
               state_in = head_item.first ? puct_pkg::ST_SQRT : puct_pkg::ST_MUL;
            end
         end
         puct_pkg::ST_SQRT: begin
            if (step_ff == 5'd0) begin
               state_in = puct_pkg::ST_MUL;
            end
         end
         puct_pkg::ST_MUL: state_in = puct_pkg::ST_DIV_SETUP;
         puct_pkg::ST_DIV_SETUP: state_in = puct_pkg::ST_DIV;
         puct_pkg::ST_DIV: begin
            if (step_ff == 5'd0) begin
               state_in = puct_pkg::ST_UPDATE;
            end
         end
         puct_pkg::ST_UPDATE: begin
            if (update_go) begin
               state_in = puct_pkg::ST_IDLE;
            end
         end
         default: state_in = puct_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output register.
   always_comb begin
      cur_in = cur_ff;
      explore_in = explore_ff;
      rad_in = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      cp_in = cp_ff;
      qa_in = qa_ff;
      ra_in = ra_ff;
      qb_in = qb_ff;
      rb_in = rb_ff;
      step_in = step_ff;
      lead_idx_in = lead_idx_ff;
      lead_score_in = lead_score_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_idx_in = out_idx_ff;
      out_score_in = out_score_ff;
      if (csr_valid && csr_ready) begin
         explore_in = csr_explore_weight;
      end
      case (state_ff)
         puct_pkg::ST_IDLE: begin
            if (head_valid) begin
               cur_in = head_item;
               // Only the first beat of a set restarts the root; later beats reuse it.
               if (head_item.first) begin
                  rad_in = {head_item.parent_visits, 32'd0};
                  srem_in = 26'd0;
                  root_in = 24'd0;
                  step_in = 5'(puct_pkg::SqrtSteps - 1);
               end
            end
         end
         puct_pkg::ST_SQRT: begin
            rad_in = {rad_ff[45:0], 2'b00};
            srem_in = sge ? 26'(srem_t - strial) : srem_t[25:0];
            root_in = {root_ff[22:0], sge};
            step_in = step_ff - 5'd1;
         end
         puct_pkg::ST_MUL: begin
            cp_in = {16'd0, explore_ff} * {16'd0, cur_ff.prior_prob};
         end
         puct_pkg::ST_DIV_SETUP: begin
            qa_in = vmag;
            ra_in = 17'd0;
            qb_in = num[55:24];
            rb_in = 17'd0;
            step_in = 5'(puct_pkg::DivSteps - 1);
         end
         puct_pkg::ST_DIV: begin
            qa_in = {qa_ff[30:0], age};
            ra_in = age ? 17'(ra_t - div_a) : ra_t[16:0];
            qb_in = {qb_ff[30:0], bge};
            rb_in = bge ? 17'(rb_t - div_b) : rb_t[16:0];
            step_in = step_ff - 5'd1;
         end
         puct_pkg::ST_UPDATE: begin
            if (update_go) begin
               if (cur_ff.final_item) begin
                  out_valid_in = 1'b1;
                  out_idx_in = take_lead ? cur_ff.index : lead_idx_ff;
                  out_score_in = take_lead ? score : lead_score_ff;
                  lead_idx_in = 6'd0;
                  lead_score_in = 48'sd0;
               end else if (take_lead) begin
                  lead_idx_in = cur_ff.index;
                  lead_score_in = score;
               end
            end
         end
         default: begin
            step_in = 5'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= puct_pkg::ST_IDLE;
         explore_ff <= puct_pkg::ExploreReset;
         lead_idx_ff <= 6'd0;
         lead_score_ff <= 48'sd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         explore_ff <= explore_in;
         lead_idx_ff <= lead_idx_in;
         lead_score_ff <= lead_score_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rad_ff <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      cp_ff <= cp_in;
      qa_ff <= qa_in;
      ra_ff <= ra_in;
      qb_ff <= qb_in;
      rb_ff <= rb_in;
      step_ff <= step_in;
      out_idx_ff <= out_idx_in;
      out_score_ff <= out_score_in;
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> state_ff == puct_pkg::ST_IDLE) else $error("pop outside idle");
   a_sqrt_first: assert property (@(posedge clock) disable iff (reset)
      state_ff == puct_pkg::ST_SQRT |-> cur_ff.first) else $error("root on later beat");
   a_emit_final: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !$past(out_valid_ff && rsp_stall)) |-> $past(cur_ff.final_item))
      else $error("result from a non-final beat");

endmodule
`default_nettype wire

>>> sim/tb_puct_action_select.sv
// Self-checking testbench for the PUCT action selector.
`timescale 1ns / 1ps
module tb_puct_action_select;

   localparam int MaxActions = 64;
   localparam int SettleCycles = 200;
   localparam longint ScoreHi = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint ScoreLo = -ScoreHi - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_explore_weight = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_prior_prob = '0;
   logic [15:0] req_child_visits = '0;
   logic signed [31:0] req_value_sum = '0;
   logic [15:0] req_parent_visits = '0;
   logic req_final_item = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [5:0] rsp_best_index;
   logic signed [47:0] rsp_best_score;

   puct_action_select uut (.*);

   always #6 clock = ~clock;

   // Expected winners, one per completed set.
   typedef struct {
      logic [5:0] index;
      logic signed [47:0] score;
   } winner_type;
   winner_type winners[$];

   // Shadow of the selector state.
   logic [15:0] weight_now = puct_pkg::ExploreReset;
   logic [5:0] lead_pos;
   longint lead_val;
   bit lead_valid;
   int set_pos;
   logic [15:0] root_n;

   int errors = 0;
   int burst_left = 0;
   int stall_mode = 0;

   // Floor square root of a 64-bit value, bit by bit.
   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   // Score of one action: mean value plus weighted exploration bonus.
   function automatic longint action_score(logic [15:0] prior, logic [15:0] visits,
                                           logic signed [31:0] vsum, logic [15:0] parent);
      longint mean;
      longint unsigned root;
      longint unsigned bonus;
      longint total;
      mean = (visits == 0) ? 0 : longint'(vsum) / longint'({48'd0, visits});
      root = floor_sqrt({16'd0, parent, 32'd0});
      bonus = (longint'(weight_now) * longint'(prior) * root) /
              ((longint'(visits) + 1) << 24);
      total = mean + longint'(bonus);
      if (total > ScoreHi) total = ScoreHi;
      if (total < ScoreLo) total = ScoreLo;
      return total;
   endfunction

   // Update the shadow state with one accepted action.
   task automatic track_action(logic [15:0] prior, logic [15:0] visits,
                               logic signed [31:0] vsum, logic [15:0] parent, bit last);
      longint sc;
      winner_type w;
      if (set_pos == 0) root_n = parent;
      sc = action_score(prior, visits, vsum, root_n);
      if (!lead_valid || sc > lead_val) begin
         lead_val = sc;
         lead_pos = set_pos[5:0];
         lead_valid = 1'b1;
      end
      if (set_pos < MaxActions - 1) set_pos++;
      if (last) begin
         w.index = lead_pos;
         w.score = lead_val[47:0];
         winners.push_back(w);
         lead_valid = 1'b0;
         lead_val = 0;
         lead_pos = '0;
         set_pos = 0;
         root_n = '0;
      end
   endtask

   // Send one action beat; the sender sometimes idles between bursts of random length.
   task automatic send_action(logic [15:0] prior, logic [15:0] visits,
                              logic signed [31:0] vsum, logic [15:0] parent, bit last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_prior_prob <= prior;
      req_child_visits <= visits;
      req_value_sum <= vsum;
      req_parent_visits <= parent;
      req_final_item <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_action(prior, visits, vsum, parent, last);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (winners.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write the exploration weight while the selector is idle.
   task automatic write_weight(logic [15:0] value);
      go_idle();
      csr_valid <= 1'b1;
      csr_explore_weight <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      weight_now = value;
   endtask

   // Mostly random values with the edges of the range mixed in.
   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [31:0] pick_sum();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'($urandom_range(0, 65536 * 4)) - 32'sd131072;
         default: return 32'($urandom);
      endcase
   endfunction

   task automatic random_set(int len);
      logic [15:0] parent;
      for (int i = 0; i < len; i++) begin
         parent = pick16();
         send_action(pick16(), pick16(), pick_sum(), parent, i == len - 1);
      end
   endtask

   // Field extremes, zero visits, zero parent count, ties and single sets.
   task automatic test_directed();
      send_action(16'h0000, 16'h0000, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
      send_action(16'hFFFF, 16'hFFFF, 32'sh8000_0000, 16'h0000, 1'b0);
      send_action(16'hFFFF, 16'h0000, 32'sh8000_0000, 16'h1234, 1'b1);
      send_action(16'h8000, 16'd3, 32'sd300000, 16'h0000, 1'b0);
      send_action(16'hFFFF, 16'd0, 32'sd5, 16'hFFFF, 1'b1);
      send_action(16'h4000, 16'd2, 32'sd65536, 16'd100, 1'b0);
      send_action(16'h4000, 16'd2, 32'sd65536, 16'd9, 1'b0);
      send_action(16'h4000, 16'd2, 32'sd65536, 16'd7, 1'b1);
      send_action(16'h0001, 16'hFFFF, 32'sh7FFF_FFFF, 16'hFFFF, 1'b1);
      send_action(16'h0000, 16'd1, -32'sd1, 16'd1, 1'b1);
      send_action(16'hFFFF, 16'd0, 32'sd0, 16'hFFFF, 1'b0);
      send_action(16'h0000, 16'd1, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
      send_action(16'h0000, 16'd0, 32'sd0, 16'h0000, 1'b1);
      send_action(16'hAAAA, 16'h5555, 32'shAAAA_5555, 16'h5555, 1'b0);
      send_action(16'h5555, 16'hAAAA, 32'sh5555_AAAA, 16'hAAAA, 1'b1);
   endtask

   // Sets longer than the index range saturate the position.
   task automatic test_long_sets();
      random_set(MaxActions + 6);
      random_set(MaxActions);
   endtask

   task automatic test_random(int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         random_set(len);
         sent += len;
      end
   endtask

   task automatic test_weights();
      write_weight(16'h0000);
      test_random(120);
      write_weight(16'hFFFF);
      test_directed();
      test_random(120);
      write_weight(16'($urandom));
      test_random(120);
      write_weight(puct_pkg::ExploreReset);
   endtask

   // Receiver stall pattern: changes mode now and then.
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) != 0);
         default: rsp_stall <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // Compare each result beat with the oldest expected winner.
   always @(posedge clock) begin
      winner_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (winners.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result beat: index %0d score %0d",
                                       rsp_best_index, rsp_best_score);
         end else begin
            w = winners.pop_front();
            if (rsp_best_index !== w.index || rsp_best_score !== w.score) begin
               errors++;
               if (errors <= 10)
                  $display("Mismatch: expected index %0d score %0d, got index %0d score %0d",
                           w.index, w.score, rsp_best_index, rsp_best_score);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      lead_valid = 1'b0;
      lead_val = 0;
      lead_pos = '0;
      set_pos = 0;
      root_n = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_sets();
      test_random(600);
      test_weights();
      test_random(100);
      go_idle();
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

>>> files.f
rtl/puct_pkg.sv
rtl/puct_front.sv
rtl/puct_back.sv
rtl/puct_action_select.sv
sim/tb_puct_action_select.sv
